// File: rtl/ptts_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and slot record type for the task table scheduler.
package ptts_pkg;

  localparam int TASK_SLOTS_DEF = 64;
  localparam int MAX_OUT        = 64;

  localparam logic [3:0] CMD_CREATE      = 4'd0;
  localparam logic [3:0] CMD_TERMINATE   = 4'd1;
  localparam logic [3:0] CMD_SLEEP       = 4'd2;
  localparam logic [3:0] CMD_WAKEUP      = 4'd3;
  localparam logic [3:0] CMD_SLEEP_RANGE = 4'd4;
  localparam logic [3:0] CMD_WAKE_RANGE  = 4'd5;
  localparam logic [3:0] CMD_KILL_RANGE  = 4'd6;
  localparam logic [3:0] CMD_GET_PRIO    = 4'd7;
  localparam logic [3:0] CMD_TICK        = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_TIMED = 2'd2;
  localparam logic [1:0] MODE_SUSP  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] prio;
    logic [30:0] ticks;
  } slot_data_t;

endpackage

// File: rtl/ptts_slot_mem.sv
`timescale 1ns / 1ps
// Per-slot record, next link and prev link memories, each with a registered read port.
module ptts_slot_mem
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int LW = $clog2(TASK_SLOTS + 1),
  parameter int IW = $clog2(TASK_SLOTS)
) (
  input  logic          clk,
  input  logic [IW-1:0] rd_addr,
  input  logic          data_we,
  input  logic [IW-1:0] data_waddr,
  input  slot_data_t    data_wdata,
  input  logic          next_we,
  input  logic [IW-1:0] next_waddr,
  input  logic [LW-1:0] next_wdata,
  input  logic          prev_we,
  input  logic [IW-1:0] prev_waddr,
  input  logic [LW-1:0] prev_wdata,
  output slot_data_t    rd_data,
  output logic [LW-1:0] rd_next,
  output logic [LW-1:0] rd_prev
);

  slot_data_t    data_mem [TASK_SLOTS];
  logic [LW-1:0] next_mem [TASK_SLOTS];
  logic [LW-1:0] prev_mem [TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    rd_data <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    rd_next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    rd_prev <= prev_mem[rd_addr];
  end

endmodule

// File: rtl/ptts_free_stack.sv
`timescale 1ns / 1ps
// LIFO of free slot ids in a memory; entries at or above the high-water mark read as their index.
module ptts_free_stack
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int LW = $clog2(TASK_SLOTS + 1),
  parameter int IW = $clog2(TASK_SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop,
  input  logic          push,
  input  logic [IW-1:0] push_slot,
  output logic [IW-1:0] top_slot,
  output logic          empty,
  output logic [LW-1:0] free_count
);

  logic [IW-1:0] mem [TASK_SLOTS];
  logic [LW-1:0] top;
  logic [LW-1:0] hwm;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_data;
  logic [IW-1:0] rd_idx;
  logic          rd_ident;
  logic [LW-1:0] top_dec;

  assign top_dec    = top - LW'(1);
  assign rd_addr    = (top < LW'(TASK_SLOTS)) ? top[IW-1:0] : '0;
  assign empty      = (top == LW'(TASK_SLOTS));
  assign free_count = LW'(TASK_SLOTS) - top;
  assign top_slot   = rd_ident ? rd_idx : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      hwm <= '0;
    end else if (pop) begin
      top <= top + LW'(1);
      if (top == hwm) begin
        hwm <= top + LW'(1);
      end
    end else if (push) begin
      top <= top_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[top_dec[IW-1:0]] <= push_slot;
    end
    rd_data  <= mem[rd_addr];
    rd_idx   <= rd_addr;
    rd_ident <= (top >= hwm);
  end

endmodule

// File: rtl/ptts_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: list walks, slot updates, link rebuild and the output register.
module ptts_ctrl
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int LW = $clog2(TASK_SLOTS + 1),
  parameter int IW = $clog2(TASK_SLOTS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [3:0]      cmd,
  input  logic [5:0]      task_id,
  input  logic [15:0]     priority_req,
  input  logic [15:0]     pri_low,
  input  logic [15:0]     pri_high,
  input  logic [30:0]     sleep_ticks,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [5:0]      result_id,
  output logic            has_task,
  output logic [15:0]     task_priority,
  output logic [6:0]      match_count,
  output logic            last,
  output logic [IW-1:0]   rd_addr,
  output logic            data_we,
  output logic [IW-1:0]   data_waddr,
  output slot_data_t      data_wdata,
  output logic            next_we,
  output logic [IW-1:0]   next_waddr,
  output logic [LW-1:0]   next_wdata,
  output logic            prev_we,
  output logic [IW-1:0]   prev_waddr,
  output logic [LW-1:0]   prev_wdata,
  input  slot_data_t      rd_data,
  input  logic [LW-1:0]   rd_next,
  input  logic [LW-1:0]   rd_prev,
  output logic            pop,
  output logic            push,
  output logic [IW-1:0]   push_slot,
  input  logic [IW-1:0]   top_slot,
  input  logic            free_empty,
  output logic [TASK_SLOTS-1:0] active_map
);

  localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD      = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_WALK_RD = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;
  localparam logic [2:0] S_INS1    = 3'd6;
  localparam logic [2:0] S_INS2    = 3'd7;

  function automatic logic [IW-1:0] link_idx(input logic [LW-1:0] l);
    logic [IW-1:0] r;
    r = (l >= NIL) ? '0 : l[IW-1:0];
    return r;
  endfunction

  function automatic slot_data_t sleep_fn(input slot_data_t d, input logic [30:0] t);
    slot_data_t r;
    r = d;
    if (t != 31'd0) begin
      r.mode  = MODE_TIMED;
      r.ticks = t;
    end else begin
      r.mode = MODE_SUSP;
    end
    return r;
  endfunction

  function automatic slot_data_t wake_fn(input slot_data_t d);
    slot_data_t r;
    r = d;
    if (d.mode == MODE_TIMED) begin
      r.mode  = MODE_READY;
      r.ticks = '0;
    end else if (d.mode == MODE_SUSP) begin
      r.mode = (d.ticks != 31'd0) ? MODE_TIMED : MODE_READY;
    end
    return r;
  endfunction

  function automatic slot_data_t tick_fn(input slot_data_t d);
    slot_data_t r;
    r = d;
    if (d.mode == MODE_TIMED) begin
      if (d.ticks > 31'd1) begin
        r.ticks = d.ticks - 31'd1;
      end else begin
        r.ticks = '0;
        r.mode  = MODE_READY;
      end
    end
    return r;
  endfunction

  logic [2:0]      state, state_next;
  logic [3:0]      cmd_r;
  logic [5:0]      id_r;
  logic [15:0]     preq_r, lo_r, hi_r;
  logic [30:0]     ticks_r;
  logic [LW-1:0]   head, head_next;
  logic [LW-1:0]   cur, cur_next;
  logic [LW-1:0]   pk, pk_next;
  logic [LW-1:0]   cnt, cnt_next;
  logic            have_pend, have_pend_next;
  logic [IW-1:0]   pend_id, pend_next;
  logic [IW-1:0]   new_slot, new_slot_next;
  logic [TASK_SLOTS-1:0] active, active_next;

  logic            accept, out_free;
  logic [IW-1:0]   id_idx, cur_idx, nx_idx;
  logic            id_ok, cur_nil, match, kill, is_tick, create_stop;
  logic            take, need_emit, step_fire;
  slot_data_t      upd_d;

  logic            emit, e_has, e_last;
  logic [1:0]      e_status;
  logic [IW-1:0]   e_id;
  logic [15:0]     e_prio;
  logic [LW-1:0]   e_cnt;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign active_map = active;

  assign id_idx  = IW'(id_r);
  assign id_ok   = (32'(id_r) < 32'(TASK_SLOTS)) && active[id_idx];
  assign cur_nil = (cur == NIL);
  assign cur_idx = link_idx(cur);
  assign nx_idx  = link_idx(rd_next);
  assign match   = (rd_data.prio >= lo_r) && (rd_data.prio <= hi_r);
  assign kill    = (cmd_r == CMD_KILL_RANGE) && match;
  assign is_tick = (cmd_r == CMD_TICK);
  assign create_stop = cur_nil || (preq_r < rd_data.prio);

  always_comb begin
    case (cmd_r)
      CMD_SLEEP_RANGE: upd_d = match ? sleep_fn(rd_data, ticks_r) : rd_data;
      CMD_WAKE_RANGE:  upd_d = match ? wake_fn(rd_data) : rd_data;
      CMD_TICK:        upd_d = tick_fn(rd_data);
      default:         upd_d = rd_data;
    endcase
  end

  // a ready task is only reported once the following one shows up or the walk ends, so last can be set
  assign take      = is_tick && (upd_d.mode == MODE_READY) && (32'(cnt) < 32'(MAX_OUT));
  assign need_emit = take && have_pend;
  assign step_fire = !need_emit || out_free;

  always_comb begin
    state_next     = state;
    head_next      = head;
    cur_next       = cur;
    pk_next        = pk;
    cnt_next       = cnt;
    have_pend_next = have_pend;
    pend_next      = pend_id;
    new_slot_next  = new_slot;
    active_next    = active;
    rd_addr        = id_idx;
    data_we        = 1'b0;
    data_waddr     = cur_idx;
    data_wdata     = upd_d;
    next_we        = 1'b0;
    next_waddr     = link_idx(pk);
    next_wdata     = cur;
    prev_we        = 1'b0;
    prev_waddr     = cur_idx;
    prev_wdata     = pk;
    pop            = 1'b0;
    push           = 1'b0;
    push_slot      = cur_idx;
    emit           = 1'b0;
    e_status       = ST_OK;
    e_id           = '0;
    e_has          = 1'b0;
    e_prio         = '0;
    e_cnt          = '0;
    e_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        cur_next       = head;
        pk_next        = NIL;
        cnt_next       = '0;
        have_pend_next = 1'b0;
        if (accept) begin
          unique case (cmd) inside
            CMD_TERMINATE, CMD_SLEEP, CMD_WAKEUP, CMD_GET_PRIO: state_next = S_RD;
            CMD_CREATE: state_next = free_empty ? S_EXEC : S_WALK_RD;
            CMD_SLEEP_RANGE, CMD_WAKE_RANGE, CMD_KILL_RANGE, CMD_TICK:
              state_next = S_WALK_RD;
            default: state_next = S_EXEC;
          endcase
        end
      end

      S_RD: begin
        state_next = S_EXEC;
      end

      S_EXEC: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (cmd_r) inside
            CMD_CREATE: e_status = ST_FULL;
            CMD_TERMINATE, CMD_SLEEP, CMD_WAKEUP, CMD_GET_PRIO: begin
              if (!id_ok) begin
                e_status = ST_NOT_FOUND;
              end else begin
                e_id  = id_idx;
                e_has = 1'b1;
                case (cmd_r)
                  CMD_TERMINATE: begin
                    active_next[id_idx] = 1'b0;
                    push      = 1'b1;
                    push_slot = id_idx;
                    if (rd_prev == NIL) begin
                      head_next = rd_next;
                    end else begin
                      next_we    = 1'b1;
                      next_waddr = link_idx(rd_prev);
                      next_wdata = rd_next;
                    end
                    if (rd_next != NIL) begin
                      prev_we    = 1'b1;
                      prev_waddr = nx_idx;
                      prev_wdata = rd_prev;
                    end
                  end
                  CMD_SLEEP: begin
                    data_we    = 1'b1;
                    data_waddr = id_idx;
                    data_wdata = sleep_fn(rd_data, ticks_r);
                  end
                  CMD_WAKEUP: begin
                    data_we    = 1'b1;
                    data_waddr = id_idx;
                    data_wdata = wake_fn(rd_data);
                  end
                  default: e_prio = rd_data.prio;
                endcase
              end
            end
            default: e_status = ST_OK;
          endcase
        end
      end

      S_WALK_RD: begin
        rd_addr    = cur_idx;
        state_next = S_WALK;
      end

      S_WALK: begin
        rd_addr = cur_idx;
        if (cmd_r == CMD_CREATE) begin
          if (create_stop) begin
            state_next = S_INS1;
          end else begin
            pk_next  = cur;
            cur_next = rd_next;
            rd_addr  = nx_idx;
          end
        end else if (cur_nil) begin
          state_next = S_FIN;
        end else if (step_fire) begin
          rd_addr  = nx_idx;
          cur_next = rd_next;
          if (kill) begin
            active_next[cur_idx] = 1'b0;
            push = 1'b1;
          end else begin
            // relink survivors behind the last kept task
            if (pk == NIL) begin
              head_next = cur;
            end else begin
              next_we = 1'b1;
            end
            prev_we = 1'b1;
            pk_next = cur;
            data_we = 1'b1;
          end
          if (is_tick) begin
            if (take) begin
              if (have_pend) begin
                emit   = 1'b1;
                e_id   = pend_id;
                e_has  = 1'b1;
                e_last = 1'b0;
              end
              pend_next      = cur_idx;
              have_pend_next = 1'b1;
              cnt_next       = cnt + LW'(1);
            end
          end else if (match) begin
            cnt_next = cnt + LW'(1);
          end
        end
      end

      S_FIN: begin
        rd_addr = cur_idx;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (pk == NIL) begin
            head_next = NIL;
          end else begin
            next_we    = 1'b1;
            next_wdata = NIL;
          end
          if (is_tick) begin
            e_id  = have_pend ? pend_id : '0;
            e_has = have_pend;
          end else begin
            e_cnt = cnt;
          end
        end
      end

      S_INS1: begin
        rd_addr       = cur_idx;
        new_slot_next = top_slot;
        pop           = 1'b1;
        active_next[top_slot] = 1'b1;
        next_we       = 1'b1;
        next_waddr    = top_slot;
        next_wdata    = cur;
        prev_we       = 1'b1;
        prev_waddr    = top_slot;
        prev_wdata    = pk;
        data_we       = 1'b1;
        data_waddr    = top_slot;
        data_wdata    = '{mode: MODE_READY, prio: preq_r, ticks: '0};
        state_next    = S_INS2;
      end

      S_INS2: begin
        rd_addr = cur_idx;
        if (out_free) begin
          emit       = 1'b1;
          e_id       = new_slot;
          e_has      = 1'b1;
          state_next = S_IDLE;
          if (pk == NIL) begin
            head_next = LW'(new_slot);
          end else begin
            next_we    = 1'b1;
            next_wdata = LW'(new_slot);
          end
          if (!cur_nil) begin
            prev_we    = 1'b1;
            prev_wdata = LW'(new_slot);
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      active    <= '0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      active    <= active_next;
      have_pend <= have_pend_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    pk       <= pk_next;
    cnt      <= cnt_next;
    pend_id  <= pend_next;
    new_slot <= new_slot_next;
    if (accept) begin
      cmd_r   <= cmd;
      id_r    <= task_id;
      preq_r  <= priority_req;
      lo_r    <= pri_low;
      hi_r    <= pri_high;
      ticks_r <= sleep_ticks;
    end
    if (emit) begin
      status        <= e_status;
      result_id     <= 6'(e_id);
      has_task      <= e_has;
      task_priority <= e_prio;
      match_count   <= 7'(e_cnt);
      last          <= e_last;
    end
  end

endmodule

// File: rtl/priority_task_table_scheduler_top.sv
`timescale 1ns / 1ps
// Priority ordered task table with sleep timers: ties the sequencer, slot memories and free stack.
// Terminate, sleep, wakeup and get priority read their slot, then update it and load the result register.
// Create walks the list to its insert point, then links in the new slot and reports it.
// Range commands and tick walk every active task, one per cycle through the slot memory
// read port, but a tick walk holds while a ready id waits on a stalled output register.
// Reset (sync, active high) empties the list and free stack pointer; memories are not cleared.
module priority_task_table_scheduler_top
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  cmd,
  input  logic [5:0]  task_id,
  input  logic [15:0] priority_req,
  input  logic [15:0] pri_low,
  input  logic [15:0] pri_high,
  input  logic [30:0] sleep_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  result_id,
  output logic        has_task,
  output logic [15:0] task_priority,
  output logic [6:0]  match_count,
  output logic        last
);

  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam int IW = $clog2(TASK_SLOTS);

  logic [IW-1:0] rd_addr;
  logic          data_we, next_we, prev_we;
  logic [IW-1:0] data_waddr, next_waddr, prev_waddr;
  slot_data_t    data_wdata, rd_data;
  logic [LW-1:0] next_wdata, prev_wdata, rd_next, rd_prev;
  logic          pop, push, free_empty;
  logic [IW-1:0] push_slot, top_slot;
  logic [LW-1:0] free_count;
  logic [TASK_SLOTS-1:0] active_map;

  ptts_slot_mem #(.TASK_SLOTS(TASK_SLOTS), .LW(LW), .IW(IW)) u_mem (
    .clk, .rd_addr,
    .data_we, .data_waddr, .data_wdata,
    .next_we, .next_waddr, .next_wdata,
    .prev_we, .prev_waddr, .prev_wdata,
    .rd_data, .rd_next, .rd_prev
  );

  ptts_free_stack #(.TASK_SLOTS(TASK_SLOTS), .LW(LW), .IW(IW)) u_free (
    .clk, .rst, .pop, .push, .push_slot, .top_slot,
    .empty(free_empty), .free_count
  );

  ptts_ctrl #(.TASK_SLOTS(TASK_SLOTS), .LW(LW), .IW(IW)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall,
    .cmd, .task_id, .priority_req, .pri_low, .pri_high, .sleep_ticks,
    .out_valid, .out_stall,
    .status, .result_id, .has_task, .task_priority, .match_count, .last,
    .rd_addr,
    .data_we, .data_waddr, .data_wdata,
    .next_we, .next_waddr, .next_wdata,
    .prev_we, .prev_waddr, .prev_wdata,
    .rd_data, .rd_next, .rd_prev,
    .pop, .push, .push_slot, .top_slot, .free_empty,
    .active_map
  );

`ifndef SYNTHESIS
  // every slot is either active or on the free stack
  a_slot_conservation: assert property (@(posedge clk) disable iff (rst)
    32'($countones(active_map)) + 32'(free_count) == 32'(TASK_SLOTS))
    else $error("slot accounting mismatch");

  a_no_id_without_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_task |-> result_id == 6'd0)
    else $error("result_id set without a task");

  a_error_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && !has_task)
    else $error("error status on a non-final or task result");

  a_count_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_count != 7'd0 |-> last && !has_task)
    else $error("match count on a task result");
`endif

endmodule

// File: tb/tb_priority_task_table_scheduler_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the priority task table scheduler: directed table, then random.
module tb_priority_task_table_scheduler_top;
  import ptts_pkg::*;

  localparam int NSLOT = 64;
  localparam logic [6:0] NIL = 7'd64;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [5:0]  task_id;
    logic [15:0] priority_req;
    logic [15:0] pri_low;
    logic [15:0] pri_high;
    logic [30:0] sleep_ticks;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  result_id;
    logic        has_task;
    logic [15:0] task_priority;
    logic [6:0]  match_count;
    logic        last;
  } sched_resp_t;

  // directed row: command plus optional typed-in first response
  typedef struct packed {
    sched_cmd_t  c;
    logic        fixed;
    sched_resp_t r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  cmd = '0;
  logic [5:0]  task_id = '0;
  logic [15:0] priority_req = '0;
  logic [15:0] pri_low = '0;
  logic [15:0] pri_high = '0;
  logic [30:0] sleep_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  result_id;
  logic        has_task;
  logic [15:0] task_priority;
  logic [6:0]  match_count;
  logic        last;

  priority_task_table_scheduler_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .task_id(task_id), .priority_req(priority_req), .pri_low(pri_low), .pri_high(pri_high),
    .sleep_ticks(sleep_ticks), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_id(result_id), .has_task(has_task),
    .task_priority(task_priority), .match_count(match_count), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the task table
  logic [1:0]  shd_mode [NSLOT];
  logic [15:0] shd_prio [NSLOT];
  logic [30:0] shd_ticks [NSLOT];
  logic [6:0]  shd_next [NSLOT];
  logic [6:0]  shd_prev [NSLOT];
  logic [6:0]  shd_head;
  logic [5:0]  shd_free [NSLOT];
  int          shd_free_cnt;

  sched_resp_t pending_resp[$];
  int errors = 0;
  int n_resp = 0;
  int n_ticks_ready = 0;
  bit quiet = 1'b0;

  function automatic sched_resp_t mk_resp(logic [1:0] st, logic [5:0] id, logic ht,
                                          logic [15:0] pr, logic [6:0] mc, logic lst);
    sched_resp_t r;
    r.status = st; r.result_id = id; r.has_task = ht;
    r.task_priority = pr; r.match_count = mc; r.last = lst;
    return r;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NSLOT; i++) begin
      shd_mode[6'(i)] = 2'd0; shd_prio[6'(i)] = '0; shd_ticks[6'(i)] = '0;
      shd_next[6'(i)] = '0; shd_prev[6'(i)] = '0; shd_free[6'(i)] = 6'(i);
    end
    shd_head = NIL;
    shd_free_cnt = NSLOT;
  endfunction

  function automatic void unlink(logic [5:0] s);
    logic [6:0] p, n;
    p = shd_prev[s]; n = shd_next[s];
    if (p >= NIL) shd_head = n; else shd_next[p[5:0]] = n;
    if (n < NIL) shd_prev[n[5:0]] = p;
  endfunction

  function automatic void drop_task(logic [5:0] s);
    shd_mode[s] = 2'd0;
    unlink(s);
    if (shd_free_cnt < NSLOT) begin
      shd_free_cnt++;
      shd_free[6'(NSLOT - shd_free_cnt)] = s;
    end
  endfunction

  function automatic void put_to_sleep(logic [5:0] s, logic [30:0] t);
    if (t != 0) begin
      shd_mode[s] = MODE_TIMED; shd_ticks[s] = t;
    end else begin
      shd_mode[s] = MODE_SUSP;
    end
  endfunction

  function automatic void wake_task(logic [5:0] s);
    if (shd_mode[s] == MODE_TIMED) begin
      shd_ticks[s] = '0; shd_mode[s] = MODE_READY;
    end else if (shd_mode[s] == MODE_SUSP) begin
      shd_mode[s] = (shd_ticks[s] != 0) ? MODE_TIMED : MODE_READY;
    end
  endfunction

  // applies one command to the shadow table and queues the responses it causes
  function automatic void schedule_step(sched_cmd_t c);
    logic [6:0] cur, nx, after;
    int cnt, k;
    bit live;
    live = shd_mode[c.task_id] != 2'd0;
    case (c.cmd)
      CMD_CREATE: begin
        if (shd_free_cnt == 0) begin
          pending_resp.push_back(mk_resp(ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          cur = {1'b0, shd_free[6'(NSLOT - shd_free_cnt)]};
          shd_free_cnt--;
          shd_mode[cur[5:0]] = MODE_READY; shd_prio[cur[5:0]] = c.priority_req;
          shd_ticks[cur[5:0]] = '0;
          after = NIL; nx = shd_head;
          while (nx < NIL && !(c.priority_req < shd_prio[nx[5:0]])) begin
            after = nx; nx = shd_next[nx[5:0]];
          end
          shd_prev[cur[5:0]] = after; shd_next[cur[5:0]] = nx;
          if (after >= NIL) shd_head = cur; else shd_next[after[5:0]] = cur;
          if (nx < NIL) shd_prev[nx[5:0]] = cur;
          pending_resp.push_back(mk_resp(ST_OK, cur[5:0], 1, 0, 0, 1));
        end
      end
      CMD_TERMINATE, CMD_SLEEP, CMD_WAKEUP, CMD_GET_PRIO: begin
        if (!live) begin
          pending_resp.push_back(mk_resp(ST_NOT_FOUND, 0, 0, 0, 0, 1));
        end else begin
          if (c.cmd == CMD_TERMINATE) drop_task(c.task_id);
          else if (c.cmd == CMD_SLEEP) put_to_sleep(c.task_id, c.sleep_ticks);
          else if (c.cmd == CMD_WAKEUP) wake_task(c.task_id);
          pending_resp.push_back(mk_resp(ST_OK, c.task_id, 1,
            (c.cmd == CMD_GET_PRIO) ? shd_prio[c.task_id] : 16'd0, 0, 1));
        end
      end
      CMD_SLEEP_RANGE, CMD_WAKE_RANGE, CMD_KILL_RANGE: begin
        cnt = 0; cur = shd_head;
        while (cur < NIL) begin
          nx = shd_next[cur[5:0]];
          if (shd_prio[cur[5:0]] >= c.pri_low && shd_prio[cur[5:0]] <= c.pri_high) begin
            if (c.cmd == CMD_SLEEP_RANGE) put_to_sleep(cur[5:0], c.sleep_ticks);
            else if (c.cmd == CMD_WAKE_RANGE) wake_task(cur[5:0]);
            else drop_task(cur[5:0]);
            cnt++;
          end
          cur = nx;
        end
        pending_resp.push_back(mk_resp(ST_OK, 0, 0, 0, 7'(cnt), 1));
      end
      CMD_TICK: begin
        for (cur = shd_head; cur < NIL; cur = shd_next[cur[5:0]])
          if (shd_mode[cur[5:0]] == MODE_TIMED) begin
            if (shd_ticks[cur[5:0]] > 1) shd_ticks[cur[5:0]]--;
            else begin
              shd_ticks[cur[5:0]] = '0; shd_mode[cur[5:0]] = MODE_READY;
            end
          end
        k = 0;
        for (cur = shd_head; cur < NIL && k < MAX_OUT; cur = shd_next[cur[5:0]])
          if (shd_mode[cur[5:0]] == MODE_READY) begin
            pending_resp.push_back(mk_resp(ST_OK, cur[5:0], 1, 0, 0, 0));
            k++;
          end
        if (k == 0) pending_resp.push_back(mk_resp(ST_OK, 0, 0, 0, 0, 1));
        else pending_resp[$].last = 1'b1;
        n_ticks_ready += k;
      end
      default: pending_resp.push_back(mk_resp(ST_OK, 0, 0, 0, 0, 1));
    endcase
  endfunction

  task automatic report_mismatch(string what, sched_resp_t got, sched_resp_t want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s at %0t: got %h want %h", what, $time, got, want);
  endtask

  // response checker
  always @(posedge clk) begin
    sched_resp_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = mk_resp(status, result_id, has_task, task_priority, match_count, last);
      n_resp++;
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected item", got, '0);
      end else begin
        want = pending_resp.pop_front();
        if (got.status !== want.status) report_mismatch("status", got, want);
        if (got.result_id !== want.result_id) report_mismatch("result_id", got, want);
        if (got.has_task !== want.has_task) report_mismatch("has_task", got, want);
        if (got.task_priority !== want.task_priority)
          report_mismatch("task_priority", got, want);
        if (got.match_count !== want.match_count) report_mismatch("match_count", got, want);
        if (got.last !== want.last) report_mismatch("last", got, want);
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    int gap;
    if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      if (gap > 0) gap--;
      else out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end
  end

  task automatic send(sched_cmd_t c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c.cmd; task_id <= c.task_id; priority_req <= c.priority_req;
    pri_low <= c.pri_low; pri_high <= c.pri_high; sleep_ticks <= c.sleep_ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_step(c);
  endtask

  function automatic sched_cmd_t mk_cmd(logic [3:0] op, logic [5:0] id, logic [15:0] pr,
                                        logic [15:0] lo, logic [15:0] hi, logic [30:0] t);
    sched_cmd_t c;
    c.cmd = op; c.task_id = id; c.priority_req = pr;
    c.pri_low = lo; c.pri_high = hi; c.sleep_ticks = t;
    return c;
  endfunction

  // random command biased toward live tasks
  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    int pick, tries;
    logic [15:0] a, b;
    c = mk_cmd(4'($urandom_range(0, 8)), 6'($urandom), 16'($urandom), 16'd0, 16'd0,
               31'($urandom_range(0, 5)));
    pick = $urandom_range(0, 99);
    if (pick < 25) c.cmd = CMD_CREATE;
    else if (pick < 35) c.cmd = CMD_TICK;
    else if (pick < 37) c.cmd = 4'($urandom_range(9, 15));
    if ($urandom_range(0, 3) != 0) c.priority_req = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) c.sleep_ticks = 31'($urandom);
    if ($urandom_range(0, 5) == 0) c.sleep_ticks = '0;
    for (tries = 0; tries < 8 && $urandom_range(0, 4) != 0; tries++) begin
      c.task_id = 6'($urandom);
      if (shd_mode[c.task_id] != 2'd0) break;
    end
    a = 16'($urandom_range(0, 15)); b = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      a = 16'($urandom); b = 16'($urandom);
    end
    c.pri_low = a; c.pri_high = b;
    // kill ranges narrow to keep the table populated
    if (c.cmd == CMD_KILL_RANGE && $urandom_range(0, 2) != 0) c.pri_high = a;
    return c;
  endfunction

  dir_row_t dir_tab [$];

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_resp.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  initial begin
    sched_cmd_t c;
    table_reset();
    // directed table: fixed rows carry the response read straight off the spec
    dir_tab.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0), 1, mk_resp(ST_OK, 0, 0, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_TERMINATE, 63, 0, 0, 0, 0), 1,
                        mk_resp(ST_NOT_FOUND, 0, 0, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_GET_PRIO, 5, 0, 0, 0, 0), 1,
                        mk_resp(ST_NOT_FOUND, 0, 0, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_CREATE, 0, 16'hFFFF, 0, 0, 0), 1,
                        mk_resp(ST_OK, 0, 1, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_CREATE, 0, 0, 0, 0, 0), 1, mk_resp(ST_OK, 1, 1, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_CREATE, 0, 16'h50, 0, 0, 0), 1,
                        mk_resp(ST_OK, 2, 1, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_CREATE, 0, 16'h50, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_GET_PRIO, 0, 0, 0, 0, 0), 1,
                        mk_resp(ST_OK, 0, 1, 16'hFFFF, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_SLEEP, 1, 0, 0, 0, 31'h7FFFFFFF), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_SLEEP, 2, 0, 0, 0, 31'd1), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_SLEEP, 3, 0, 0, 0, 31'd0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_WAKEUP, 3, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_SLEEP, 1, 0, 0, 0, 31'd0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_WAKEUP, 1, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_SLEEP_RANGE, 0, 0, 16'h0, 16'hFFFF, 31'd2), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_WAKE_RANGE, 0, 0, 16'h50, 16'h50, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(CMD_WAKE_RANGE, 0, 0, 16'hFFFF, 16'h0, 0), 1,
                        mk_resp(ST_OK, 0, 0, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk_cmd(4'd15, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF), 1,
                        mk_resp(ST_OK, 0, 0, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(4'd9, 0, 0, 0, 0, 0), 1, mk_resp(ST_OK, 0, 0, 0, 0, 1)});
    dir_tab.push_back('{mk_cmd(CMD_KILL_RANGE, 0, 0, 16'h0, 16'hFFFF, 0), 1,
                        mk_resp(ST_OK, 0, 0, 0, 7'd4, 1)});
    dir_tab.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0), 1, mk_resp(ST_OK, 0, 0, 0, 0, 1)});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send(dir_tab[i].c);
      // typed-in value must agree with the predictor's first response
      if (dir_tab[i].fixed && pending_resp[$] !== dir_tab[i].r)
        report_mismatch("directed row", pending_resp[$], dir_tab[i].r);
    end
    in_valid <= 1'b0;
    wait_drained();

    // fill the table past full, then random traffic
    for (int i = 0; i < 66; i++) send(mk_cmd(CMD_CREATE, 0, 16'($urandom), 0, 0, 0));
    send(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    send(mk_cmd(CMD_KILL_RANGE, 0, 0, 16'h0, 16'hFFFF, 0));
    for (int i = 0; i < 410; i++) begin
      if (i == 205) wait_drained();
      if (i == 340) quiet = 1'b1;
      c = rand_cmd();
      send(c);
    end
    wait_drained();
    $display("covered %0d responses, %0d ready ids from ticks, table fill and overflow",
             n_resp, n_ticks_ready);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("PASS priority_task_table_scheduler_top");
    end else begin
      $display("FAIL priority_task_table_scheduler_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL priority_task_table_scheduler_top");
    $finish;
  end

endmodule
